FILE: rtl/assert_macros.svh
// shared assertion macros for the tracker checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk_s, rst_ok, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_ok)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk_s, rst_ok, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_ok)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/lot_pkg.sv
`timescale 1ns / 1ps
package lot_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int ID_SPACE_DEF = 256;
  localparam int ID_W = 8;
  localparam int CNT_W = 7;
  localparam int FUNC_W = 3;
  localparam int STS_W = 2;

  // operation codes
  localparam logic [FUNC_W-1:0] F_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] F_TOUCH = 3'd1;
  localparam logic [FUNC_W-1:0] F_REMOVE = 3'd2;
  localparam logic [FUNC_W-1:0] F_POP = 3'd3;
  localparam logic [FUNC_W-1:0] F_RESIZE = 3'd4;

  // result status codes
  localparam logic [STS_W-1:0] ST_OK = 2'd0;
  localparam logic [STS_W-1:0] ST_REFUSED = 2'd1;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STS_W-1:0] ST_ABSENT = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_INS_CHECK,
    S_RSZ_CHECK,
    S_UNLINK,
    S_PUSH,
    S_EV_OUT,
    S_REPLY
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr;
    logic cap;
    logic ld_tgt;
    logic tgt_tail;
    logic unlink;
    logic push;
    logic set_lim;
    logic emit;
    logic e_valid;
    logic e_last;
    logic [STS_W-1:0] e_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic in_space;
    logic present;
    logic head_eq_id;
    logic count_zero;
    logic lim_zero;
    logic count_ge_lim;
    logic count_gt_lim;
    logic k_zero;
    logic k_ok_ins;
    logic k_ok_rsz;
    logic out_free;
    logic [FUNC_W-1:0] func;
  } stat_t;

endpackage

FILE: rtl/lot_ctrl.sv
`timescale 1ns / 1ps
module lot_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  lot_pkg::stat_t st,
  output lot_pkg::cmd_t  cmd
);

  lot_pkg::state_t state_r, state_nxt;
  logic [lot_pkg::STS_W-1:0] sts_r, sts_nxt;

  // state and pending reply status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lot_pkg::S_CLEAR;
      sts_r   <= lot_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      sts_r   <= sts_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    sts_nxt   = sts_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      lot_pkg::S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) state_nxt = lot_pkg::S_IDLE;
      end
      lot_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = lot_pkg::S_DECODE;
        end
      end
      lot_pkg::S_DECODE: begin
        case (st.func)
          lot_pkg::F_INSERT: begin
            if (st.lim_zero) begin
              sts_nxt   = lot_pkg::ST_REFUSED;
              state_nxt = lot_pkg::S_REPLY;
            end else if (!st.in_space || st.present) begin
              sts_nxt   = lot_pkg::ST_ABSENT;
              state_nxt = lot_pkg::S_REPLY;
            end else begin
              state_nxt = lot_pkg::S_INS_CHECK;
            end
          end
          lot_pkg::F_TOUCH: begin
            if (!st.present) begin
              sts_nxt   = lot_pkg::ST_ABSENT;
              state_nxt = lot_pkg::S_REPLY;
            end else if (st.head_eq_id) begin
              sts_nxt   = lot_pkg::ST_OK;
              state_nxt = lot_pkg::S_REPLY;
            end else begin
              cmd.ld_tgt = 1'b1;
              state_nxt  = lot_pkg::S_UNLINK;
            end
          end
          lot_pkg::F_REMOVE: begin
            if (st.count_zero) begin
              sts_nxt   = lot_pkg::ST_EMPTY;
              state_nxt = lot_pkg::S_REPLY;
            end else if (!st.present) begin
              sts_nxt   = lot_pkg::ST_ABSENT;
              state_nxt = lot_pkg::S_REPLY;
            end else begin
              cmd.ld_tgt = 1'b1;
              state_nxt  = lot_pkg::S_UNLINK;
            end
          end
          lot_pkg::F_POP: begin
            if (st.count_zero) begin
              sts_nxt   = lot_pkg::ST_EMPTY;
              state_nxt = lot_pkg::S_REPLY;
            end else begin
              cmd.ld_tgt   = 1'b1;
              cmd.tgt_tail = 1'b1;
              state_nxt    = lot_pkg::S_UNLINK;
            end
          end
          lot_pkg::F_RESIZE: begin
            cmd.set_lim = 1'b1;
            state_nxt   = lot_pkg::S_RSZ_CHECK;
          end
          default: begin
            sts_nxt   = lot_pkg::ST_OK;
            state_nxt = lot_pkg::S_REPLY;
          end
        endcase
      end
      // evict from the tail until there is room, then link at the head
      lot_pkg::S_INS_CHECK: begin
        if (st.count_ge_lim && !st.count_zero && st.k_ok_ins) begin
          cmd.ld_tgt   = 1'b1;
          cmd.tgt_tail = 1'b1;
          state_nxt    = lot_pkg::S_UNLINK;
        end else begin
          cmd.push  = 1'b1;
          sts_nxt   = lot_pkg::ST_OK;
          state_nxt = lot_pkg::S_REPLY;
        end
      end
      // shrink to the new limit
      lot_pkg::S_RSZ_CHECK: begin
        if (st.count_gt_lim && st.k_ok_rsz) begin
          cmd.ld_tgt   = 1'b1;
          cmd.tgt_tail = 1'b1;
          state_nxt    = lot_pkg::S_UNLINK;
        end else if (st.k_zero) begin
          sts_nxt   = lot_pkg::ST_OK;
          state_nxt = lot_pkg::S_REPLY;
        end else begin
          state_nxt = lot_pkg::S_IDLE;
        end
      end
      lot_pkg::S_UNLINK: begin
        cmd.unlink = 1'b1;
        case (st.func)
          lot_pkg::F_TOUCH:  state_nxt = lot_pkg::S_PUSH;
          lot_pkg::F_REMOVE: begin
            sts_nxt   = lot_pkg::ST_OK;
            state_nxt = lot_pkg::S_REPLY;
          end
          default: state_nxt = lot_pkg::S_EV_OUT;
        endcase
      end
      lot_pkg::S_PUSH: begin
        cmd.push  = 1'b1;
        sts_nxt   = lot_pkg::ST_OK;
        state_nxt = lot_pkg::S_REPLY;
      end
      // report an evicted or popped id
      lot_pkg::S_EV_OUT: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.e_valid  = 1'b1;
          cmd.e_status = lot_pkg::ST_OK;
          case (st.func)
            lot_pkg::F_POP: begin
              cmd.e_last = 1'b1;
              state_nxt  = lot_pkg::S_IDLE;
            end
            lot_pkg::F_RESIZE: begin
              cmd.e_last = !st.count_gt_lim;
              state_nxt  = lot_pkg::S_RSZ_CHECK;
            end
            default: state_nxt = lot_pkg::S_INS_CHECK;
          endcase
        end
      end
      lot_pkg::S_REPLY: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.e_status = sts_r;
          cmd.e_last   = 1'b1;
          state_nxt    = lot_pkg::S_IDLE;
        end
      end
      default: state_nxt = lot_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: rtl/lot_dp.sv
`timescale 1ns / 1ps
module lot_dp #(
  parameter int CAPACITY = lot_pkg::CAPACITY_DEF,
  parameter int ID_SPACE = lot_pkg::ID_SPACE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lot_pkg::cmd_t               cmd,
  output lot_pkg::stat_t              st,
  input  logic [lot_pkg::FUNC_W-1:0]  in_func,
  input  logic [lot_pkg::ID_W-1:0]    in_entry_id,
  input  logic [lot_pkg::CNT_W-1:0]   in_new_limit,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lot_pkg::ID_W-1:0]    out_out_id,
  output logic                        out_id_valid,
  output logic [lot_pkg::STS_W-1:0]   out_status,
  output logic [lot_pkg::CNT_W-1:0]   out_occupancy,
  output logic                        out_last
);

  localparam int AW = $clog2(ID_SPACE);
  localparam int IW = lot_pkg::ID_W;
  localparam int CW = lot_pkg::CNT_W;

  // link and membership memories
  logic [IW-1:0] hl_mem [ID_SPACE];
  logic [IW-1:0] tl_mem [ID_SPACE];
  logic          mb_mem [ID_SPACE];

  logic [IW-1:0] hl_q, tl_q;
  logic          mb_q;

  logic [lot_pkg::FUNC_W-1:0] func_r;
  logic [IW-1:0] id_r, tgt_r;
  logic [CW-1:0] nlim_r;
  logic [IW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt, limit_r, k_r;
  logic [AW-1:0] clr_addr_r;
  logic          out_valid_r;

  logic          hl_we, tl_we, mb_we, mb_wd;
  logic [AW-1:0] hl_wa, tl_wa, mb_wa;
  logic [IW-1:0] hl_wd, tl_wd;
  logic [IW-1:0] tgt_sel;
  logic          up_ok, dn_ok;

  assign tgt_sel = cmd.tgt_tail ? tail_r : id_r;
  assign up_ok   = {24'd0, hl_q} < 32'(ID_SPACE);
  assign dn_ok   = {24'd0, tl_q} < 32'(ID_SPACE);

  // list pointer updates and memory writes for unlink and push
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    hl_we = 1'b0; hl_wa = '0; hl_wd = '0;
    tl_we = 1'b0; tl_wa = '0; tl_wd = '0;
    mb_we = 1'b0; mb_wa = '0; mb_wd = 1'b0;
    if (cmd.clr) begin
      mb_we = 1'b1;
      mb_wa = clr_addr_r;
    end else if (cmd.unlink) begin
      if (count_r <= CW'(1)) begin
        head_nxt = '0;
        tail_nxt = '0;
      end else if (head_r == tgt_r) begin
        head_nxt = tl_q;
      end else if (tail_r == tgt_r) begin
        tail_nxt = hl_q;
      end else if (up_ok && dn_ok) begin
        tl_we = 1'b1; tl_wa = AW'(hl_q); tl_wd = tl_q;
        hl_we = 1'b1; hl_wa = AW'(tl_q); hl_wd = hl_q;
      end
      mb_we = 1'b1;
      mb_wa = AW'(tgt_r);
      if (count_r != '0) count_nxt = count_r - CW'(1);
    end else if (cmd.push) begin
      if (count_r == '0) begin
        head_nxt = id_r;
        tail_nxt = id_r;
      end else begin
        hl_we = 1'b1; hl_wa = AW'(head_r); hl_wd = id_r;
        tl_we = 1'b1; tl_wa = AW'(id_r);   tl_wd = head_r;
        head_nxt = id_r;
      end
      mb_we = 1'b1;
      mb_wa = AW'(id_r);
      mb_wd = 1'b1;
      count_nxt = count_r + CW'(1);
    end
  end

  // memories, registered reads
  always_ff @(posedge clk) begin
    if (hl_we) hl_mem[hl_wa] <= hl_wd;
    if (cmd.ld_tgt) hl_q <= hl_mem[AW'(tgt_sel)];
  end

  always_ff @(posedge clk) begin
    if (tl_we) tl_mem[tl_wa] <= tl_wd;
    if (cmd.ld_tgt) tl_q <= tl_mem[AW'(tgt_sel)];
  end

  always_ff @(posedge clk) begin
    if (mb_we) mb_mem[mb_wa] <= mb_wd;
    if (cmd.cap) mb_q <= mb_mem[AW'(in_entry_id)];
  end

  // captured item and target
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      func_r <= in_func;
      id_r   <= in_entry_id;
      nlim_r <= in_new_limit;
    end
    if (cmd.ld_tgt) tgt_r <= tgt_sel;
  end

  // list control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      limit_r    <= CW'(CAPACITY);
      k_r        <= '0;
      clr_addr_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (cmd.set_lim)
        limit_r <= (nlim_r > CW'(CAPACITY)) ? CW'(CAPACITY) : nlim_r;
      if (cmd.cap) k_r <= '0;
      else if (cmd.emit) k_r <= k_r + CW'(1);
      if (cmd.clr) clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_out_id    <= cmd.e_valid ? tgt_r : '0;
      out_id_valid  <= cmd.e_valid;
      out_status    <= cmd.e_status;
      out_occupancy <= count_r;
      out_last      <= cmd.e_last;
    end
  end

  assign out_valid = out_valid_r;

  // status to the controller
  always_comb begin
    st.clr_last     = (clr_addr_r == AW'(ID_SPACE - 1));
    st.in_space     = {24'd0, id_r} < 32'(ID_SPACE);
    st.present      = st.in_space && mb_q;
    st.head_eq_id   = (head_r == id_r);
    st.count_zero   = (count_r == '0);
    st.lim_zero     = (limit_r == '0);
    st.count_ge_lim = (count_r >= limit_r);
    st.count_gt_lim = (count_r > limit_r);
    st.k_zero       = (k_r == '0);
    st.k_ok_ins     = (k_r < CW'(CAPACITY - 1));
    st.k_ok_rsz     = (k_r < CW'(CAPACITY));
    st.out_free     = !out_valid_r || !out_stall;
    st.func         = func_r;
  end

endmodule

FILE: rtl/lru_order_tracker_core.sv
// LRU order tracker: keeps ids in least-recently-used order as a doubly linked
// list in two link memories plus a membership memory. Operations are insert,
// touch, remove, pop least recent and resize; each gives one or more results,
// the final one flagged by out_last. One item is worked at a time. Each id
// evicted takes a link memory read, an unlink write and a result, and a
// stalled result channel holds the item back. After reset the membership
// memory is swept clear, one entry per cycle, during which no item is
// accepted.
`timescale 1ns / 1ps
module lru_order_tracker_core #(
  parameter int CAPACITY = lot_pkg::CAPACITY_DEF,
  parameter int ID_SPACE = lot_pkg::ID_SPACE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lot_pkg::FUNC_W-1:0]  in_func,
  input  logic [lot_pkg::ID_W-1:0]    in_entry_id,
  input  logic [lot_pkg::CNT_W-1:0]   in_new_limit,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lot_pkg::ID_W-1:0]    out_out_id,
  output logic                        out_id_valid,
  output logic [lot_pkg::STS_W-1:0]   out_status,
  output logic [lot_pkg::CNT_W-1:0]   out_occupancy,
  output logic                        out_last
);

  lot_pkg::cmd_t  cmd;
  lot_pkg::stat_t st;

  // sequencer
  lot_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // list memories and pointers
  lot_dp #(
    .CAPACITY (CAPACITY),
    .ID_SPACE (ID_SPACE)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_func       (in_func),
    .in_entry_id   (in_entry_id),
    .in_new_limit  (in_new_limit),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_out_id    (out_out_id),
    .out_id_valid  (out_id_valid),
    .out_status    (out_status),
    .out_occupancy (out_occupancy),
    .out_last      (out_last)
  );

endmodule

FILE: rtl/lot_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lot_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [lot_pkg::ID_W-1:0]    out_out_id,
  input logic                        out_id_valid,
  input logic [lot_pkg::STS_W-1:0]   out_status,
  input logic                        out_last
);

  // result fields gathered for the hold check
  logic [lot_pkg::ID_W+lot_pkg::STS_W:0] out_word;
  assign out_word = {out_out_id, out_status, out_last};

  // a stalled result holds
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))

  // an evicted id only comes with an ok status
  `ASSERT_IMP(a_id_ok, clk, rst_n, out_valid && out_id_valid, out_status == lot_pkg::ST_OK)

  // no id reported without its flag
  `ASSERT_IMP(a_id_zero, clk, rst_n, out_valid && !out_id_valid, out_out_id == '0)

  // an error reply always ends its item
  `ASSERT_IMP(a_err_last, clk, rst_n, out_valid && out_status != lot_pkg::ST_OK, out_last)

  // nothing taken or shown right after reset
  `ASSERT_NXT(a_rst_quiet, clk, 1'b1, !rst_n, in_stall && !out_valid)

endmodule

bind lru_order_tracker_core lot_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_out_id   (out_out_id),
  .out_id_valid (out_id_valid),
  .out_status   (out_status),
  .out_last     (out_last)
);
